// ===== rtl/ast_pkg.sv =====
`default_nettype none

package ast_pkg;

   // table size and field limits
   localparam int SLOTS       = 16;
   localparam int TAG_WIDTH   = 8;
   localparam int MAX_MESSAGE = 32;
   localparam int RESULT_CAP  = 16;

   localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W  = $clog2(RESULT_CAP + 1);

   // fixed field widths
   localparam int FUNC_W       = 2;
   localparam int HOUR_W       = 5;
   localparam int MIN_W        = 6;
   localparam int MSG_W        = 8;
   localparam int LEN_W        = 6;
   localparam int STATUS_W     = 3;
   localparam int SLOT_FIELD_W = 4;

   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 16;

   // range limits for a set command
   localparam logic [HOUR_W-1:0] HOUR_MAX = 5'd23;
   localparam logic [MIN_W-1:0]  MIN_MAX  = 6'd59;
   localparam logic [LEN_W-1:0]  LEN_MAX  = LEN_W'(MAX_MESSAGE);

   // command codes
   localparam logic [FUNC_W-1:0] FUNC_SET  = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_FREE = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_TICK = 2'd2;
   localparam logic [FUNC_W-1:0] FUNC_NONE = 2'd3;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
   localparam logic [STATUS_W-1:0] ST_HOUR_BAD   = 3'd1;
   localparam logic [STATUS_W-1:0] ST_MINUTE_BAD = 3'd2;
   localparam logic [STATUS_W-1:0] ST_LENGTH_BAD = 3'd3;
   localparam logic [STATUS_W-1:0] ST_FULL       = 3'd4;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND  = 3'd5;

   // controller to datapath
   typedef struct packed {
      logic                load;
      logic                step;
      logic                write_slot;
      logic                clear_slot;
      logic                capture;
      logic                set_status;
      logic [STATUS_W-1:0] status;
      logic                push;
      logic                push_last;
   } ast_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [FUNC_W-1:0]   func;
      logic [STATUS_W-1:0] arg_status;
      logic                hit;
      logic                at_end;
      logic                cap_next;
      logic                pend_fired;
   } ast_stat_type;

endpackage

`default_nettype wire

// ===== rtl/ast_ctrl.sv =====
`default_nettype none

module ast_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  ast_pkg::ast_stat_type stat,
   output ast_pkg::ast_cmd_type  cmd
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SCAN = 2'd1;
   localparam logic [1:0] S_DONE = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       out_free;

   // output register can take a beat this cycle
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   // next state and datapath commands
   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            unique case (stat.func)
               ast_pkg::FUNC_SET: begin
                  if (stat.arg_status != ast_pkg::ST_OK) begin
                     cmd.set_status = 1'b1;
                     cmd.status     = stat.arg_status;
                     state_in       = S_DONE;
                  end else if (stat.hit) begin
                     cmd.write_slot = 1'b1;
                     cmd.set_status = 1'b1;
                     cmd.status     = ast_pkg::ST_OK;
                     state_in       = S_DONE;
                  end else if (stat.at_end) begin
                     cmd.set_status = 1'b1;
                     cmd.status     = ast_pkg::ST_FULL;
                     state_in       = S_DONE;
                  end else begin
                     cmd.step = 1'b1;
                  end
               end
               ast_pkg::FUNC_FREE: begin
                  if (stat.hit) begin
                     cmd.clear_slot = 1'b1;
                     cmd.set_status = 1'b1;
                     cmd.status     = ast_pkg::ST_OK;
                     state_in       = S_DONE;
                  end else if (stat.at_end) begin
                     cmd.set_status = 1'b1;
                     cmd.status     = ast_pkg::ST_NOT_FOUND;
                     state_in       = S_DONE;
                  end else begin
                     cmd.step = 1'b1;
                  end
               end
               ast_pkg::FUNC_TICK: begin
                  // a held hit goes out before the next one is captured
                  if (stat.hit) begin
                     if (!stat.pend_fired || out_free) begin
                        if (stat.pend_fired) begin
                           cmd.push      = 1'b1;
                           cmd.push_last = 1'b0;
                           rsp_valid_in  = 1'b1;
                        end
                        cmd.capture    = 1'b1;
                        cmd.clear_slot = 1'b1;
                        if (stat.at_end || stat.cap_next) begin
                           state_in = S_DONE;
                        end else begin
                           cmd.step = 1'b1;
                        end
                     end
                  end else if (stat.at_end) begin
                     state_in = S_DONE;
                  end else begin
                     cmd.step = 1'b1;
                  end
               end
               ast_pkg::FUNC_NONE: begin
                  state_in = S_DONE;
               end
            endcase
         end
         S_DONE: begin
            if (out_free) begin
               cmd.push      = 1'b1;
               cmd.push_last = 1'b1;
               rsp_valid_in  = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state and result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/ast_dpath.sv =====
`default_nettype none

module ast_dpath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  ast_pkg::ast_cmd_type                 cmd,
   output ast_pkg::ast_stat_type                stat,
   input  logic [ast_pkg::FUNC_W-1:0]           func,
   input  logic [ast_pkg::HOUR_W-1:0]           hour,
   input  logic [ast_pkg::MIN_W-1:0]            minute,
   input  logic [ast_pkg::MSG_W-1:0]            message_tag,
   input  logic [ast_pkg::LEN_W-1:0]            message_length,
   output logic [ast_pkg::STATUS_W-1:0]         status,
   output logic                                 fired,
   output logic [ast_pkg::SLOT_FIELD_W-1:0]     fired_slot,
   output logic [ast_pkg::MSG_W-1:0]            fired_message,
   output logic                                 last
);

   // latched command
   logic [ast_pkg::FUNC_W-1:0]    func_ff;
   logic [ast_pkg::HOUR_W-1:0]    hour_ff;
   logic [ast_pkg::MIN_W-1:0]     minute_ff;
   logic [ast_pkg::TAG_WIDTH-1:0] tag_ff;
   logic [ast_pkg::LEN_W-1:0]     len_ff;

   // scan position and fire count
   logic [ast_pkg::SLOT_W-1:0] idx_ff;
   logic [ast_pkg::SLOT_W-1:0] idx_in;
   logic [ast_pkg::CNT_W-1:0]  count_ff;

   // held result
   logic [ast_pkg::STATUS_W-1:0]  pend_status_ff;
   logic                          pend_fired_ff;
   logic [ast_pkg::SLOT_W-1:0]    pend_slot_ff;
   logic [ast_pkg::TAG_WIDTH-1:0] pend_msg_ff;

   // slot table
   logic                          valid_ff [ast_pkg::SLOTS];
   logic [ast_pkg::HOUR_W-1:0]    slot_hour_ff [ast_pkg::SLOTS];
   logic [ast_pkg::MIN_W-1:0]     slot_minute_ff [ast_pkg::SLOTS];
   logic [ast_pkg::TAG_WIDTH-1:0] slot_msg_ff [ast_pkg::SLOTS];

   // output register
   logic [ast_pkg::STATUS_W-1:0]     out_status_ff;
   logic                             out_fired_ff;
   logic [ast_pkg::SLOT_FIELD_W-1:0] out_slot_ff;
   logic [ast_pkg::MSG_W-1:0]        out_msg_ff;
   logic                             out_last_ff;

   logic                          cur_valid;
   logic [ast_pkg::HOUR_W-1:0]    cur_hour;
   logic [ast_pkg::MIN_W-1:0]     cur_minute;
   logic [ast_pkg::STATUS_W-1:0]  arg_status;
   logic                          hit;

   // read of the slot under the scan pointer
   assign cur_valid  = valid_ff[idx_ff];
   assign cur_hour   = slot_hour_ff[idx_ff];
   assign cur_minute = slot_minute_ff[idx_ff];

   // operand checks for a set, in priority order
   always_comb begin
      priority if (hour_ff > ast_pkg::HOUR_MAX) begin
         arg_status = ast_pkg::ST_HOUR_BAD;
      end else if (minute_ff > ast_pkg::MIN_MAX) begin
         arg_status = ast_pkg::ST_MINUTE_BAD;
      end else if (len_ff == '0 || len_ff > ast_pkg::LEN_MAX) begin
         arg_status = ast_pkg::ST_LENGTH_BAD;
      end else begin
         arg_status = ast_pkg::ST_OK;
      end
   end

   // per-command slot match
   always_comb begin
      unique case (func_ff)
         ast_pkg::FUNC_SET:  hit = !cur_valid;
         ast_pkg::FUNC_FREE: hit = cur_valid && cur_hour == hour_ff && cur_minute == minute_ff;
         ast_pkg::FUNC_TICK: hit = cur_valid && cur_hour == hour_ff && minute_ff >= cur_minute;
         ast_pkg::FUNC_NONE: hit = 1'b0;
      endcase
   end

   assign idx_in = cmd.load ? '0 : ast_pkg::SLOT_W'(idx_ff + 1'b1);

   // status to controller
   always_comb begin
      stat            = '0;
      stat.func       = func_ff;
      stat.arg_status = arg_status;
      stat.hit        = hit;
      stat.at_end     = (idx_ff == ast_pkg::SLOT_W'(ast_pkg::SLOTS - 1));
      stat.cap_next   = (count_ff == ast_pkg::CNT_W'(ast_pkg::RESULT_CAP - 1));
      stat.pend_fired = pend_fired_ff;
   end

   // command latch, scan pointer and held result
   always_ff @(posedge clock) begin
      if (reset) begin
         func_ff <= ast_pkg::FUNC_NONE;
      end else if (cmd.load) begin
         func_ff <= func;
      end
      if (cmd.load) begin
         hour_ff   <= hour;
         minute_ff <= minute;
         tag_ff    <= ast_pkg::TAG_WIDTH'(message_tag);
         len_ff    <= message_length;
      end
      if (cmd.load || cmd.step) begin
         idx_ff <= idx_in;
      end
      if (cmd.load) begin
         count_ff       <= '0;
         pend_status_ff <= ast_pkg::ST_OK;
         pend_fired_ff  <= 1'b0;
         pend_slot_ff   <= '0;
         pend_msg_ff    <= '0;
      end else if (cmd.capture) begin
         count_ff       <= ast_pkg::CNT_W'(count_ff + 1'b1);
         pend_status_ff <= ast_pkg::ST_OK;
         pend_fired_ff  <= 1'b1;
         pend_slot_ff   <= idx_ff;
         pend_msg_ff    <= slot_msg_ff[idx_ff];
      end else if (cmd.set_status) begin
         pend_status_ff <= cmd.status;
      end
   end

   // slot contents, written only on a set
   always_ff @(posedge clock) begin
      if (cmd.write_slot) begin
         slot_hour_ff[idx_ff]   <= hour_ff;
         slot_minute_ff[idx_ff] <= minute_ff;
         slot_msg_ff[idx_ff]    <= tag_ff;
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ast_pkg::SLOTS; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else if (cmd.write_slot) begin
         valid_ff[idx_ff] <= 1'b1;
      end else if (cmd.clear_slot) begin
         valid_ff[idx_ff] <= 1'b0;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (cmd.push) begin
         out_status_ff <= pend_status_ff;
         out_fired_ff  <= pend_fired_ff;
         out_slot_ff   <= ast_pkg::SLOT_FIELD_W'(pend_slot_ff);
         out_msg_ff    <= ast_pkg::MSG_W'(pend_msg_ff);
         out_last_ff   <= cmd.push_last;
      end
   end

   assign status        = out_status_ff;
   assign fired         = out_fired_ff;
   assign fired_slot    = out_slot_ff;
   assign fired_message = out_msg_ff;
   assign last          = out_last_ff;

endmodule

`default_nettype wire

// ===== rtl/alarm_slot_table.sv =====
// channel   dir  tdata                                     tuser       tlast
// req       in   hour, minute, message_tag, message_length  func        -
// rsp       out  status, fired_slot, fired_message          fired       last
//
// one command at a time: the request beat is taken, the table is scanned one
// slot per cycle through its single read port, a tick holding on a hit while
// the output register holds an untaken beat, and the final beat is pushed;
// a finished beat waits for the output register while the result side stalls.
// reset is synchronous and clears the valid bits and handshake state at once.
// a new request beat is taken while the last result beat still waits.
`default_nettype none

module alarm_slot_table (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // hour [4:0], minute [10:5], message_tag [18:11], message_length [24:19]
   input  logic [ast_pkg::REQ_DATA_W-1:0]   req_tdata,
   // func [1:0]
   input  logic [ast_pkg::FUNC_W-1:0]       req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // status [2:0], fired_slot [6:3], fired_message [14:7]
   output logic [ast_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // fired [0]
   output logic                             rsp_tuser,
   output logic                             rsp_tlast
);

   ast_pkg::ast_cmd_type  cmd;
   ast_pkg::ast_stat_type stat;

   logic [ast_pkg::STATUS_W-1:0]     status;
   logic                             fired;
   logic [ast_pkg::SLOT_FIELD_W-1:0] fired_slot;
   logic [ast_pkg::MSG_W-1:0]        fired_message;
   logic                             last;

   // controller
   ast_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   // slot table and result register
   ast_dpath u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .func           (req_tuser),
      .hour           (req_tdata[4:0]),
      .minute         (req_tdata[10:5]),
      .message_tag    (req_tdata[18:11]),
      .message_length (req_tdata[24:19]),
      .status         (status),
      .fired          (fired),
      .fired_slot     (fired_slot),
      .fired_message  (fired_message),
      .last           (last)
   );

   // result beat packing
   assign rsp_tdata = {1'b0, fired_message, fired_slot, status};
   assign rsp_tuser = fired;
   assign rsp_tlast = last;

`ifndef SYNTH
   // one command in flight: no new beat right after one is taken
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request taken while a command is in flight");

   // a beat without a fired alarm always closes its command
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> rsp_tlast)
      else $error("non-fired result without last");

   // a beat without a fired alarm carries no slot or tag
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> (rsp_tdata[14:3] == 12'd0))
      else $error("non-fired result with slot or tag set");

   // a fired beat always reports ok
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata[2:0] == ast_pkg::ST_OK))
      else $error("fired result with error status");
`endif

endmodule

`default_nettype wire

// ===== verif/alarm_slot_table_tb.sv =====
`default_nettype none

module alarm_slot_table_tb;
   timeunit 1ns;
   timeprecision 1ps;

   // one result beat as the table reports it
   typedef struct packed {
      logic [ast_pkg::STATUS_W-1:0]     status;
      logic                             fired;
      logic [ast_pkg::SLOT_FIELD_W-1:0] slot;
      logic [ast_pkg::MSG_W-1:0]        message;
      logic                             last;
   } alarm_result_type;

   localparam int CYCLE_LIMIT  = 500000;
   localparam int SETTLE_TICKS = ast_pkg::SLOTS + 8;

   logic                           clock      = 1'b0;
   logic                           reset      = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [ast_pkg::REQ_DATA_W-1:0] req_tdata  = '0;
   logic [ast_pkg::FUNC_W-1:0]     req_tuser  = ast_pkg::FUNC_NONE;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [ast_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                           rsp_tuser;
   logic                           rsp_tlast;

   // shadow copy of the alarm table
   logic                       alarm_valid  [ast_pkg::SLOTS];
   logic [ast_pkg::HOUR_W-1:0] alarm_hour   [ast_pkg::SLOTS];
   logic [ast_pkg::MIN_W-1:0]  alarm_minute [ast_pkg::SLOTS];
   logic [ast_pkg::MSG_W-1:0]  alarm_tag    [ast_pkg::SLOTS];

   alarm_result_type pending_results [$];

   int req_idle_pct  = 0;
   int rsp_idle_pct  = 0;
   int rsp_hold_left = 0;
   int mismatches    = 0;
   int commands_sent = 0;
   int beats_checked = 0;
   int alarms_fired  = 0;
   int cycles        = 0;

   always #5 clock = ~clock;

   alarm_slot_table i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // run guard
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("run stopped at cycle %0d, %0d beats still outstanding",
                  cycles, pending_results.size());
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   function automatic void report_mismatch(input string what,
                                           input alarm_result_type want,
                                           input alarm_result_type got);
      mismatches++;
      if (mismatches <= 10) begin
         $display("%0t %s: expected st=%0d fired=%0b slot=%0d msg=%0h last=%0b",
                  $realtime, what, want.status, want.fired, want.slot, want.message,
                  want.last);
         $display("   got st=%0d fired=%0b slot=%0d msg=%0h last=%0b",
                  got.status, got.fired, got.slot, got.message, got.last);
      end
   endfunction

   // table behavior for one command, queues the beats it must produce
   function automatic void apply_command(input logic [ast_pkg::FUNC_W-1:0] func,
                                         input logic [ast_pkg::HOUR_W-1:0] hour,
                                         input logic [ast_pkg::MIN_W-1:0] minute,
                                         input logic [ast_pkg::MSG_W-1:0] tag,
                                         input logic [ast_pkg::LEN_W-1:0] len);
      alarm_result_type r;
      int               n;
      bit               done;
      r      = '0;
      r.last = 1'b1;
      n      = 0;
      done   = 1'b0;
      case (func)
         ast_pkg::FUNC_SET: begin
            if (hour > ast_pkg::HOUR_MAX) r.status = ast_pkg::ST_HOUR_BAD;
            else if (minute > ast_pkg::MIN_MAX) r.status = ast_pkg::ST_MINUTE_BAD;
            else if (len == '0 || len > ast_pkg::LEN_MAX) r.status = ast_pkg::ST_LENGTH_BAD;
            else begin
               r.status = ast_pkg::ST_FULL;
               for (int i = 0; i < ast_pkg::SLOTS; i++) begin
                  if (!done && !alarm_valid[i]) begin
                     alarm_valid[i]  = 1'b1;
                     alarm_hour[i]   = hour;
                     alarm_minute[i] = minute;
                     alarm_tag[i]    = ast_pkg::MSG_W'(tag[ast_pkg::TAG_WIDTH-1:0]);
                     r.status        = ast_pkg::ST_OK;
                     done            = 1'b1;
                  end
               end
            end
            pending_results.push_back(r);
         end
         ast_pkg::FUNC_FREE: begin
            r.status = ast_pkg::ST_NOT_FOUND;
            for (int i = 0; i < ast_pkg::SLOTS; i++) begin
               if (!done && alarm_valid[i] && alarm_hour[i] == hour
                   && alarm_minute[i] == minute) begin
                  alarm_valid[i] = 1'b0;
                  r.status       = ast_pkg::ST_OK;
                  done           = 1'b1;
               end
            end
            pending_results.push_back(r);
         end
         ast_pkg::FUNC_TICK: begin
            // fire due slots lowest first, one beat each
            for (int i = 0; i < ast_pkg::SLOTS; i++) begin
               if (n < ast_pkg::RESULT_CAP && alarm_valid[i] && alarm_hour[i] == hour
                   && minute >= alarm_minute[i]) begin
                  alarm_valid[i] = 1'b0;
                  r              = '0;
                  r.status       = ast_pkg::ST_OK;
                  r.fired        = 1'b1;
                  r.slot         = ast_pkg::SLOT_FIELD_W'(i);
                  r.message      = alarm_tag[i];
                  pending_results.push_back(r);
                  n++;
               end
            end
            if (n == 0) begin
               r      = '0;
               r.last = 1'b1;
               pending_results.push_back(r);
            end else begin
               pending_results[pending_results.size()-1].last = 1'b1;
            end
         end
         default: begin
            pending_results.push_back(r);
         end
      endcase
   endfunction

   // result side: stall pattern, long hold-off and beat checking
   always @(posedge clock) begin
      alarm_result_type got;
      alarm_result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.status  = rsp_tdata[ast_pkg::STATUS_W-1:0];
            got.slot    = rsp_tdata[ast_pkg::STATUS_W +: ast_pkg::SLOT_FIELD_W];
            got.message = rsp_tdata[ast_pkg::STATUS_W+ast_pkg::SLOT_FIELD_W +: ast_pkg::MSG_W];
            got.fired   = rsp_tuser;
            got.last    = rsp_tlast;
            beats_checked++;
            if (got.fired) alarms_fired++;
            if (pending_results.size() == 0) begin
               report_mismatch("unexpected result beat", '0, got);
            end else begin
               want = pending_results.pop_front();
               if (got !== want) report_mismatch("result beat differs", want, got);
            end
         end
         if (rsp_hold_left > 0) begin
            rsp_hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   // offer one command beat and wait for it to be taken
   task automatic send_command(input logic [ast_pkg::FUNC_W-1:0] func,
                               input logic [ast_pkg::HOUR_W-1:0] hour,
                               input logic [ast_pkg::MIN_W-1:0] minute,
                               input logic [ast_pkg::MSG_W-1:0] tag,
                               input logic [ast_pkg::LEN_W-1:0] len);
      while ($urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= func;
      req_tdata  <= ast_pkg::REQ_DATA_W'({len, tag, minute, hour});
      do @(posedge clock); while (!req_tready);
      apply_command(func, hour, minute, tag, len);
      commands_sent++;
   endtask

   // sender stays quiet until every queued beat has come back
   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
   endtask

   // random occupied slot, -1 when the table is empty
   function automatic int random_live_slot();
      int start;
      int idx;
      start = $urandom_range(ast_pkg::SLOTS-1);
      for (int k = 0; k < ast_pkg::SLOTS; k++) begin
         idx = (start + k) % ast_pkg::SLOTS;
         if (alarm_valid[idx]) return idx;
      end
      return -1;
   endfunction

   // range checks on set, unused code, empty table cases
   task automatic test_rejects();
      send_command(ast_pkg::FUNC_SET, 5'd31, 6'd0, 8'h00, ast_pkg::LEN_W'(1));
      send_command(ast_pkg::FUNC_SET, 5'd23, 6'd63, 8'hff,
                   ast_pkg::LEN_W'(ast_pkg::MAX_MESSAGE));
      send_command(ast_pkg::FUNC_SET, 5'd0, 6'd59, 8'h5a, '0);
      send_command(ast_pkg::FUNC_SET, 5'd1, 6'd1, 8'ha5,
                   ast_pkg::LEN_W'(ast_pkg::MAX_MESSAGE + 1));
      send_command(ast_pkg::FUNC_NONE, '1, '1, '1, '1);
      send_command(ast_pkg::FUNC_TICK, 5'd0, 6'd0, '0, '0);
      send_command(ast_pkg::FUNC_FREE, 5'd0, 6'd0, '0, '0);
      send_command(ast_pkg::FUNC_TICK, 5'd31, 6'd63, '0, '0);
   endtask

   // fill every slot, overflow, free one, refill, then fire them all at once
   task automatic test_full_table();
      for (int i = 0; i < ast_pkg::SLOTS; i++)
         send_command(ast_pkg::FUNC_SET, 5'd23, 6'd59, ast_pkg::MSG_W'(i * 17),
                      (i % 2) ? ast_pkg::LEN_W'(ast_pkg::MAX_MESSAGE) : ast_pkg::LEN_W'(1));
      send_command(ast_pkg::FUNC_SET, 5'd12, 6'd30, 8'h77, ast_pkg::LEN_W'(4));
      send_command(ast_pkg::FUNC_FREE, 5'd23, 6'd59, '0, '0);
      send_command(ast_pkg::FUNC_SET, 5'd23, 6'd59, 8'hc3, ast_pkg::LEN_W'(9));
      send_command(ast_pkg::FUNC_TICK, 5'd23, 6'd59, '0, '0);
   endtask

   // result side holds off while commands keep coming, then everything drains
   task automatic test_backpressure();
      wait_for_results();
      rsp_hold_left = 400;
      for (int i = 0; i < 10; i++)
         send_command(ast_pkg::FUNC_SET, 5'd5, ast_pkg::MIN_W'(10 + i),
                      ast_pkg::MSG_W'($urandom_range(255)), ast_pkg::LEN_W'(3));
      send_command(ast_pkg::FUNC_TICK, 5'd5, 6'd14, '0, '0);
      send_command(ast_pkg::FUNC_TICK, 5'd5, 6'd63, '0, '0);
      wait_for_results();
   endtask

   // mostly well-formed traffic around a few hours so ticks keep firing
   task automatic test_random(input int count);
      int                         r;
      int                         s;
      logic [ast_pkg::HOUR_W-1:0] hr;
      logic [ast_pkg::MIN_W-1:0]  mn;
      for (int n = 0; n < count; n++) begin
         r  = $urandom_range(99);
         hr = ($urandom_range(3) == 0) ? ast_pkg::HOUR_W'($urandom_range(23))
                                       : ast_pkg::HOUR_W'($urandom_range(2));
         mn = ast_pkg::MIN_W'($urandom_range(59));
         s  = random_live_slot();
         if (r < 40) begin
            send_command(ast_pkg::FUNC_SET, hr, mn, ast_pkg::MSG_W'($urandom_range(255)),
                         ast_pkg::LEN_W'($urandom_range(ast_pkg::MAX_MESSAGE, 1)));
         end else if (r < 55) begin
            if (s >= 0 && $urandom_range(3) != 0)
               send_command(ast_pkg::FUNC_FREE, alarm_hour[s], alarm_minute[s], '0, '0);
            else
               send_command(ast_pkg::FUNC_FREE, hr, mn,
                            ast_pkg::MSG_W'($urandom_range(255)), '0);
         end else if (r < 80) begin
            if (s >= 0 && $urandom_range(1) != 0)
               send_command(ast_pkg::FUNC_TICK, alarm_hour[s],
                            ast_pkg::MIN_W'(alarm_minute[s] + $urandom_range(3)), '0, '0);
            else
               send_command(ast_pkg::FUNC_TICK, hr,
                            ast_pkg::MIN_W'($urandom_range(63)), '0, '0);
         end else if (r < 95) begin
            send_command(ast_pkg::FUNC_W'($urandom_range(3)),
                         ast_pkg::HOUR_W'($urandom_range(31)),
                         ast_pkg::MIN_W'($urandom_range(63)),
                         ast_pkg::MSG_W'($urandom_range(255)),
                         ast_pkg::LEN_W'($urandom_range(63)));
         end else begin
            send_command(ast_pkg::FUNC_NONE, ast_pkg::HOUR_W'($urandom_range(31)),
                         ast_pkg::MIN_W'($urandom_range(63)),
                         ast_pkg::MSG_W'($urandom_range(255)),
                         ast_pkg::LEN_W'($urandom_range(63)));
         end
      end
   endtask

   initial begin
      foreach (alarm_valid[i]) begin
         alarm_valid[i]  = 1'b0;
         alarm_hour[i]   = '0;
         alarm_minute[i] = '0;
         alarm_tag[i]    = '0;
      end
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      req_idle_pct = 16;
      rsp_idle_pct = 52;
      test_rejects();
      test_full_table();
      test_backpressure();
      test_random(130);

      req_idle_pct = 52;
      rsp_idle_pct = 16;
      test_random(130);

      req_idle_pct = 0;
      rsp_idle_pct = 0;
      test_random(130);

      // drain and give the block time to show any stray beat
      wait_for_results();
      repeat (SETTLE_TICKS) @(posedge clock);
      while (pending_results.size() != 0)
         report_mismatch("result never arrived", pending_results.pop_front(), '0);

      $display("%0d commands, %0d result beats checked, %0d fired alarms",
               commands_sent, beats_checked, alarms_fired);
      $display("range rejects, full table, free hit and miss, multi-slot ticks, long output stall");
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("%0d mismatching beats", mismatches);
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== files.f =====
rtl/ast_pkg.sv
rtl/ast_ctrl.sv
rtl/ast_dpath.sv
rtl/alarm_slot_table.sv
verif/alarm_slot_table_tb.sv
